/* rtl/timer_bank_deadline_scheduler_top_macros.svh */
// Assertion macros shared by the timer bank RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef TIMER_BANK_DEADLINE_SCHEDULER_TOP_MACROS_SVH
`define TIMER_BANK_DEADLINE_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TBDS_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBDS_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tbds_pkg.sv */
// Package for the timer bank: field widths, word layouts, codes and the
// command and status structs between controller and datapath. No dependencies.
package tbds_pkg;

   // Field widths.
   localparam int OP_W     = 2;
   localparam int SLOT_W   = 4;
   localparam int PERIOD_W = 32;
   localparam int TIME_W   = 64;
   localparam int SCALE_W  = 20;
   localparam int PROD_W   = PERIOD_W + SCALE_W;

   // Nanoseconds per millisecond.
   localparam logic [SCALE_W-1:0] NS_PER_MS = 20'd1000000;

   // Request word layout: slot, interval in ms, single-shot flag, current time,
   // zero fill.
   localparam int SLOT_LSB   = 0;
   localparam int IVL_LSB    = SLOT_LSB + SLOT_W;
   localparam int ONCE_BIT   = IVL_LSB + PERIOD_W;
   localparam int NOW_LSB    = ONCE_BIT + 1;
   localparam int REQ_DATA_W = 104;

   // Result word layout: status, fired_slot, zero fill.
   localparam int RSP_DATA_W = 8;

   // Slot store entry: {single_shot, period_ms, deadline_ns}.
   localparam int ENTRY_W = 1 + PERIOD_W + TIME_W;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START_MUL,
      ST_START_WR,
      ST_ACK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN_HIT,
      ST_SCAN_END
   } state_type;

   // Kind of result word loaded into the output register.
   typedef enum logic [1:0] {
      EMIT_ACK,
      EMIT_PEND,
      EMIT_FINAL
   } emit_type;

   typedef struct packed {
      logic     load_req;
      logic     stop_clr;
      logic     idx_clr;
      logic     idx_inc;
      logic     mul_start;
      logic     mul_en;
      logic     start_wr;
      logic     ram_rd;
      logic     hit;
      logic     emit_en;
      emit_type emit_kind;
   } ctl_cmd_type;

   typedef struct packed {
      op_type req_op;
      logic   req_bad;
      logic   cur_armed;
      logic   idx_last;
      logic   due;
      logic   pend_valid;
      logic   out_free;
   } dp_stat_type;

endpackage

/* rtl/tbds_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No package dependencies.
module tbds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/tbds_ctrl.sv */
// Controller for the timer bank: sequences start, stop and tick scans.
// Depends on tbds_pkg and the assertion macro header.
`include "timer_bank_deadline_scheduler_top_macros.svh"

module tbds_ctrl
   import tbds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      hit_go;

   // A due slot may be taken once the previous pending report, if any, can be pushed.
   assign hit_go = !stat.pend_valid || stat.out_free;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (stat.req_op)
                  OP_TICK:  state_in = ST_SCAN_RD;
                  OP_START: state_in = stat.req_bad ? ST_ACK : ST_START_MUL;
                  default:  state_in = ST_ACK;
               endcase
            end
         end
         ST_START_MUL: state_in = ST_START_WR;
         ST_START_WR:  state_in = ST_ACK;
         ST_ACK: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            if (stat.cur_armed) begin
               state_in = ST_SCAN_CHK;
            end else if (stat.idx_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_CHK: begin
            if (stat.due) begin
               state_in = ST_SCAN_HIT;
            end else if (stat.idx_last) begin
               state_in = ST_SCAN_END;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_HIT: begin
            if (hit_go) begin
               state_in = stat.idx_last ? ST_SCAN_END : ST_SCAN_RD;
            end
         end
         ST_SCAN_END: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd           = '0;
      cmd.emit_kind = EMIT_ACK;
      req_tready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
            cmd.idx_clr  = req_tvalid;
            cmd.stop_clr = req_tvalid && (stat.req_op == OP_STOP);
         end
         ST_START_MUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_en    = 1'b1;
         end
         ST_START_WR: begin
            cmd.start_wr = 1'b1;
         end
         ST_ACK: begin
            cmd.emit_en   = stat.out_free;
            cmd.emit_kind = EMIT_ACK;
         end
         ST_SCAN_RD: begin
            cmd.ram_rd  = stat.cur_armed;
            cmd.idx_inc = !stat.cur_armed;
         end
         ST_SCAN_CHK: begin
            cmd.mul_en  = 1'b1;
            cmd.idx_inc = !stat.due;
         end
         ST_SCAN_HIT: begin
            cmd.hit       = hit_go;
            cmd.idx_inc   = hit_go;
            cmd.emit_en   = hit_go && stat.pend_valid;
            cmd.emit_kind = EMIT_PEND;
         end
         ST_SCAN_END: begin
            cmd.emit_en   = stat.out_free;
            cmd.emit_kind = EMIT_FINAL;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // A result word is only loaded when the output register can take it.
   `TBDS_ASSERT_IMP(a_emit_free, cmd.emit_en, stat.out_free, "emit while output busy")
   // A hit is only reached from a deadline check.
   `TBDS_ASSERT_IMP(a_hit_from_chk, state_ff == ST_SCAN_HIT,
      $past(state_ff) == ST_SCAN_CHK || $past(state_ff) == ST_SCAN_HIT,
      "hit state entered without a check")
   // An accepted request word always starts its sequence.
   `TBDS_ASSERT_NXT(a_accept_busy, req_tvalid && req_tready, state_ff != ST_IDLE,
      "accepted word left the controller idle")

endmodule

/* rtl/tbds_dp.sv */
// Datapath for the timer bank: request latch, armed flags, scan index,
// shared interval multiplier, deadline adder and the result register.
// Depends on tbds_pkg and the assertion macro header; drives the slot RAM.
`include "timer_bank_deadline_scheduler_top_macros.svh"

module tbds_dp
   import tbds_pkg::*;
#(
   parameter int NUM_TIMERS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [OP_W-1:0]          req_tuser,
   input  logic [REQ_DATA_W-1:0]    req_tdata,
   input  ctl_cmd_type              cmd,
   output dp_stat_type              stat,
   output logic                     ram_we,
   output logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] ram_waddr,
   output logic [ENTRY_W-1:0]       ram_wdata,
   output logic                     ram_re,
   output logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] ram_raddr,
   input  logic [ENTRY_W-1:0]       ram_rdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_W-1:0]    rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);

   localparam int IDX_W = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;

   // Request fields.
   op_type              req_op;
   logic [SLOT_W-1:0]   req_slot;
   logic [PERIOD_W-1:0] req_ivl;
   logic                req_once;
   logic [TIME_W-1:0]   req_now;
   logic                req_slot_ok;
   logic                req_bad;

   // Latched request.
   logic                bad_ff;
   logic [IDX_W-1:0]    slot_ff;
   logic [PERIOD_W-1:0] interval_ff;
   logic                once_ff;
   logic [TIME_W-1:0]   now_ff;

   // Slot state and scan.
   logic [NUM_TIMERS-1:0] armed_ff;
   logic [NUM_TIMERS-1:0] armed_in;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      idx_in;
   logic                  pend_valid_ff;
   logic                  pend_valid_in;
   logic [IDX_W-1:0]      pend_slot_ff;

   // Arithmetic.
   logic                rd_once;
   logic [PERIOD_W-1:0] rd_period;
   logic [TIME_W-1:0]   rd_deadline;
   logic [PERIOD_W-1:0] mul_a;
   logic [PROD_W-1:0]   prod_ff;
   logic [TIME_W-1:0]   sum;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              status_ff;
   logic              fired_ff;
   logic [SLOT_W-1:0] fslot_ff;
   logic              last_ff;
   logic              out_free;

   // Unpack the request word.
   assign req_op      = op_type'(req_tuser);
   assign req_slot    = req_tdata[SLOT_LSB +: SLOT_W];
   assign req_ivl     = req_tdata[IVL_LSB +: PERIOD_W];
   assign req_once    = req_tdata[ONCE_BIT];
   assign req_now     = req_tdata[NOW_LSB +: TIME_W];
   assign req_slot_ok = int'(req_slot) < NUM_TIMERS;
   assign req_bad     = (req_ivl == '0) || !req_slot_ok;

   // Latch the accepted request.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         bad_ff      <= (req_op == OP_START) && req_bad;
         slot_ff     <= IDX_W'(req_slot);
         interval_ff <= req_ivl;
         once_ff     <= req_once;
         now_ff      <= req_now;
      end
   end

   // Slot store read word.
   assign rd_once     = ram_rdata[ENTRY_W-1];
   assign rd_period   = ram_rdata[TIME_W +: PERIOD_W];
   assign rd_deadline = ram_rdata[TIME_W-1:0];

   // Shared interval-to-nanosecond multiplier, registered.
   assign mul_a = cmd.mul_start ? interval_ff : rd_period;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(NS_PER_MS);
      end
   end

   // New deadline, wrapping modulo 2^64.
   assign sum = now_ff + TIME_W'(prod_ff);

   // Slot store writes: arm on start, rearm a due periodic slot.
   assign ram_we    = cmd.start_wr || (cmd.hit && !rd_once);
   assign ram_waddr = cmd.start_wr ? slot_ff : idx_ff;
   assign ram_wdata = cmd.start_wr ? {once_ff, interval_ff, sum}
                                   : {rd_once, rd_period, sum};
   assign ram_re    = cmd.ram_rd;
   assign ram_raddr = idx_ff;

   // Armed flags.
   always_comb begin
      armed_in = armed_ff;
      if (cmd.stop_clr && req_slot_ok) begin
         armed_in[IDX_W'(req_slot)] = 1'b0;
      end
      if (cmd.start_wr) begin
         armed_in[slot_ff] = 1'b1;
      end
      if (cmd.hit && rd_once) begin
         armed_in[idx_ff] = 1'b0;
      end
   end

   // Scan index and the held report of the latest due slot.
   always_comb begin
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.idx_clr) begin
         idx_in        = '0;
         pend_valid_in = 1'b0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.hit) begin
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         armed_ff      <= armed_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hit) begin
         pend_slot_ff <= idx_ff;
      end
   end

   // Output register: loads when empty or when its word is taken.
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = cmd.emit_en ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_en) begin
         case (cmd.emit_kind)
            EMIT_PEND: begin
               status_ff <= 1'b0;
               fired_ff  <= 1'b1;
               fslot_ff  <= SLOT_W'(pend_slot_ff);
               last_ff   <= 1'b0;
            end
            EMIT_FINAL: begin
               status_ff <= 1'b0;
               fired_ff  <= pend_valid_ff;
               fslot_ff  <= pend_valid_ff ? SLOT_W'(pend_slot_ff) : '0;
               last_ff   <= 1'b1;
            end
            default: begin
               status_ff <= bad_ff;
               fired_ff  <= 1'b0;
               fslot_ff  <= '0;
               last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SLOT_W - 1){1'b0}}, fslot_ff, status_ff};
   assign rsp_tuser  = fired_ff;
   assign rsp_tlast  = last_ff;

   // Status to the controller.
   assign stat.req_op     = req_op;
   assign stat.req_bad    = req_bad;
   assign stat.cur_armed  = armed_ff[idx_ff];
   assign stat.idx_last   = idx_ff == IDX_W'(NUM_TIMERS - 1);
   assign stat.due        = now_ff >= rd_deadline;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;

   // A slot is never armed with a zero interval.
   `TBDS_ASSERT_IMP(a_start_nonzero, cmd.start_wr, interval_ff != '0,
      "start write with zero interval")
   // Expiry reports always carry success status.
   `TBDS_ASSERT_IMP(a_fired_status, rsp_valid_ff && fired_ff, !status_ff,
      "fired word with error status")
   // A new request drops any held report.
   `TBDS_ASSERT_NXT(a_pend_cleared, cmd.idx_clr, !pend_valid_ff,
      "held report survived a new request")

endmodule

/* rtl/timer_bank_deadline_scheduler_top.sv */
// Channel   Ports        Word contents (lowest bit first)
// request   req_*        tuser: op; tdata: slot, period, once, now_ns
// result    rsp_*        tuser: fired; tdata: status, fired_slot; tlast: last
//
// One request word is handled at a time. Stop, unused op, rejected start: accept,
// then the result word loads from the ack state once the output register is free.
// Start: multiply, slot write, then the result word. Tick: a disarmed slot is
// skipped, an armed slot is read and checked, and a due slot takes a hit step,
// paced by the single slot RAM read port and the registered shared multiplier;
// a final word ends the scan. Reset clears the armed flags; no clearing pass runs.
// A stalled result channel holds the scan at a due slot or the final word.
// Top level of the timer bank; instantiates tbds_ctrl, tbds_dp and tbds_ram.
module timer_bank_deadline_scheduler_top
   import tbds_pkg::*;
#(
   parameter int NUM_TIMERS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [OP_W-1:0]       req_tuser,  // [1:0] op
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [3:0] slot, [35:4] period,
                                             // [36] once, [100:37] now_ns
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [0] status, [4:1] fired_slot
   output logic                  rsp_tuser,  // [0] fired
   output logic                  rsp_tlast
);

   localparam int IDX_W = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;

   ctl_cmd_type        cmd;
   dp_stat_type        stat;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic               ram_re;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   tbds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tbds_dp #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Per-slot store: one-shot flag, period and deadline.
   tbds_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TIMERS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

/* sim/timer_bank_deadline_scheduler_top_tb.sv */
// Self-checking testbench for the timer bank deadline scheduler: directed and
// random start, stop, tick and unused-op words, each result checked against a local model.
// Depends on tbds_pkg and timer_bank_deadline_scheduler_top from the rtl folder.
module timer_bank_deadline_scheduler_top_tb;
   import tbds_pkg::*;

   localparam int          SLOTS        = 16;
   localparam logic [63:0] NS_PER_MILLI = 64'd1000000;
   localparam int          IDLE_LIMIT   = 3000;
   localparam int          RANDOM_WORDS = 194;
   localparam int          TAIL_CYCLES  = 80;

   // One request word as the scheduler sees it, plus how the driver presents it.
   typedef struct {
      op_type      op;
      logic [3:0]  slot;
      logic [31:0] ivl;
      logic        once;
      logic [63:0] now;
      int          gap;
      bit          drain;
   } timer_cmd_type;

   typedef struct packed {
      logic       status;
      logic       fired;
      logic [3:0] slot;
      logic       last;
   } timer_rsp_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [OP_W-1:0]       req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   timer_cmd_type cmd_q[$];
   timer_cmd_type cmd_cur;
   bit            cmd_busy = 1'b0;
   int            cmd_gap = 0;
   timer_rsp_type expected_rsp_q[$];

   // Local copy of the slot bank.
   bit          slot_armed[SLOTS];
   bit          slot_once[SLOTS];
   logic [31:0] slot_period[SLOTS];
   logic [63:0] slot_deadline[SLOTS];

   int fail_count = 0;
   int n_tick = 0, n_start = 0, n_stop = 0, n_nop = 0;
   int n_fired = 0, n_rejected = 0, max_burst = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   int stall_phase = 0;
   bit stall_quiet = 1'b0;

   timer_bank_deadline_scheduler_top #(
      .NUM_TIMERS(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Work out the result words that one accepted request word causes.
   function void predict_timer_results(timer_cmd_type c);
      timer_rsp_type r;
      timer_rsp_type found[SLOTS];
      int hits;
      hits = 0;
      case (c.op)
         OP_TICK: begin
            n_tick++;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_armed[i] && c.now >= slot_deadline[i]) begin
                  if (slot_once[i]) begin
                     slot_armed[i] = 1'b0;
                  end else begin
                     slot_deadline[i] = c.now + {32'd0, slot_period[i]} * NS_PER_MILLI;
                  end
                  found[hits] = '{status: 1'b0, fired: 1'b1, slot: i[3:0], last: 1'b0};
                  hits++;
               end
            end
            if (hits == 0) begin
               r = '{status: 1'b0, fired: 1'b0, slot: 4'd0, last: 1'b1};
               expected_rsp_q.push_back(r);
            end else begin
               found[hits-1].last = 1'b1;
               for (int i = 0; i < hits; i++) expected_rsp_q.push_back(found[i]);
            end
            n_fired += hits;
            if (hits > max_burst) max_burst = hits;
         end
         OP_START: begin
            n_start++;
            if (c.ivl == 32'd0) begin
               n_rejected++;
               r = '{status: 1'b1, fired: 1'b0, slot: 4'd0, last: 1'b1};
            end else begin
               slot_armed[c.slot]    = 1'b1;
               slot_once[c.slot]     = c.once;
               slot_period[c.slot]   = c.ivl;
               slot_deadline[c.slot] = c.now + {32'd0, c.ivl} * NS_PER_MILLI;
               r = '{status: 1'b0, fired: 1'b0, slot: 4'd0, last: 1'b1};
            end
            expected_rsp_q.push_back(r);
         end
         OP_STOP: begin
            n_stop++;
            slot_armed[c.slot] = 1'b0;
            r = '{status: 1'b0, fired: 1'b0, slot: 4'd0, last: 1'b1};
            expected_rsp_q.push_back(r);
         end
         default: begin
            n_nop++;
            r = '{status: 1'b0, fired: 1'b0, slot: 4'd0, last: 1'b1};
            expected_rsp_q.push_back(r);
         end
      endcase
   endfunction

   task automatic queue_cmd(input op_type op, input logic [3:0] slot, input logic [31:0] ivl,
                            input logic once, input logic [63:0] now, input int gap,
                            input bit drain);
      timer_cmd_type c;
      c.op    = op;
      c.slot  = slot;
      c.ivl   = ivl;
      c.once  = once;
      c.now   = now;
      c.gap   = gap;
      c.drain = drain;
      cmd_q.push_back(c);
   endtask

   // Request driver: presents queued words at the falling edge, honoring gaps
   // and the occasional wait for every outstanding result word.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!cmd_busy) begin
         if (cmd_q.size() != 0 && cmd_gap == 0) begin
            cmd_gap = cmd_q[0].gap;
         end
         if (cmd_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (cmd_gap > 0) begin
            cmd_gap--;
            cmd_q[0].gap = cmd_gap;
            req_tvalid <= 1'b0;
         end else if (cmd_q[0].drain && expected_rsp_q.size() != 0) begin
            req_tvalid <= 1'b0;
         end else begin
            cmd_cur = cmd_q.pop_front();
            cmd_busy = 1'b1;
            req_tuser  <= cmd_cur.op;
            req_tdata  <= {3'b000, cmd_cur.now, cmd_cur.once, cmd_cur.ivl, cmd_cur.slot};
            req_tvalid <= 1'b1;
         end
      end
   end

   // Result receiver: random stalls, with quiet stretches that start no new stall.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_phase++;
         if (stall_phase % 200 == 0) stall_quiet = ($urandom_range(0, 2) == 0);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!stall_quiet && $urandom_range(0, 99) < 30) stall_left = pick_gap();
         end
      end
   end

   // Monitor: predicts on each accepted request word and checks each result word.
   always @(posedge clock) begin
      timer_rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_timer_results(cmd_cur);
            cmd_busy = 1'b0;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected result word: status %0d fired %0d slot %0d last %0d",
                      rsp_tdata[0], rsp_tuser, rsp_tdata[4:1], rsp_tlast);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_tdata[0] !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tuser !== want.fired) begin
                  $error("fired mismatch: expected %0d, got %0d", want.fired, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[4:1] !== want.slot) begin
                  $error("fired_slot mismatch: expected %0d, got %0d",
                         want.slot, rsp_tdata[4:1]);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last mismatch: expected %0d, got %0d", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog: too long without any word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [63:0] clock_ns;
      logic [31:0] ivl;
      op_type      op;
      int          sel;
      bit          burst;

      for (int i = 0; i < SLOTS; i++) slot_armed[i] = 1'b0;

      // Directed words: empty tick, rejected start, wrapping deadline, rearm of
      // an armed slot, stop of an idle slot, unused op, deadline boundaries,
      // periodic rearm, and a tick that finds every slot due.
      queue_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 64'd0, pick_gap(), 1'b0);
      queue_cmd(OP_START, 4'd3, 32'd0, 1'b1, 64'd5000, pick_gap(), 1'b0);
      queue_cmd(OP_START, 4'd15, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, pick_gap(),
                1'b0);
      queue_cmd(OP_START, 4'd0, 32'd1, 1'b1, 64'd1000, pick_gap(), 1'b0);
      queue_cmd(OP_START, 4'd5, 32'd2, 1'b0, 64'd1000, pick_gap(), 1'b0);
      queue_cmd(OP_START, 4'd5, 32'd3, 1'b0, 64'd1000, pick_gap(), 1'b0);
      queue_cmd(OP_STOP, 4'd7, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, pick_gap(),
                1'b0);
      queue_cmd(OP_NOP, 4'd15, 32'hFFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, pick_gap(),
                1'b0);
      queue_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 64'd1000999, pick_gap(), 1'b0);
      queue_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 64'd1001000, pick_gap(), 1'b0);
      queue_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 64'd3001000, pick_gap(), 1'b0);
      for (int i = 0; i < SLOTS - 1; i++) begin
         if (i != 5) begin
            queue_cmd(OP_START, i[3:0], 32'(i + 1), i[0], 64'd6001000, pick_gap(), 1'b0);
         end
      end
      queue_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 64'h8000_0000_0000_0000, pick_gap(), 1'b0);

      // Random words: mostly a steadily advancing clock with short intervals so
      // that slots keep expiring, plus jumps, wraparound and unused ops.
      clock_ns = 64'h8000_0000_0000_0000;
      burst = 1'b0;
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (k % 40 == 0) burst = ($urandom_range(0, 2) == 0);
         sel = $urandom_range(0, 99);
         if (sel < 4) begin
            clock_ns = {$urandom, $urandom};
         end else if (sel < 7) begin
            clock_ns = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 40) * NS_PER_MILLI;
         end else begin
            clock_ns = clock_ns + $urandom_range(0, 12) * NS_PER_MILLI
                       + $urandom_range(0, 999999);
         end
         sel = $urandom_range(0, 99);
         if (sel < 40) op = OP_TICK;
         else if (sel < 78) op = OP_START;
         else if (sel < 95) op = OP_STOP;
         else op = OP_NOP;
         sel = $urandom_range(0, 99);
         if (op != OP_START) ivl = $urandom;
         else if (sel < 8) ivl = 32'd0;
         else if (sel < 18) ivl = $urandom;
         else ivl = $urandom_range(1, 30);
         queue_cmd(op, 4'($urandom_range(0, SLOTS - 1)), ivl, 1'($urandom_range(0, 1)),
                   (op == OP_TICK || op == OP_START) ? clock_ns : {$urandom, $urandom},
                   burst ? 0 : pick_gap(), (k % 55 == 0));
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_q.size() != 0 || cmd_busy || expected_rsp_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d ticks with %0d slot expiries (up to %0d from one tick),",
               n_tick, n_fired, max_burst);
      $display("%0d starts (%0d rejected), %0d stops and %0d unused-op words.",
               n_start, n_rejected, n_stop, n_nop);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
